FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers shared by the RTL. Define ASSERT_OFF to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion violated");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion violated");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Types, constants and the equal-tempered ratio table for the semitone
// phase increment scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

	localparam int INC_W     = 32;
	localparam int RATIO_W   = 17;
	localparam int REM_W     = RATIO_W + 1;
	localparam int ADJ_W     = 18;
	localparam int OCT_MAX   = 10;   // most octaves an 8-bit interval can hold

	localparam logic [7:0]  SEMIS_PER_OCTAVE = 8'd12;
	// x / 12 == (x * 171) >> 11 for x <= 128
	localparam logic [15:0] SEMI_RECIP       = 16'd171;
	localparam int          SEMI_RECIP_SHIFT = 11;

	localparam logic signed [18:0] UNITY_Q16      = 19'sd65536;
	localparam logic signed [18:0] CENTS_STEP_Q16 = 19'sd38;

	// floor(2^48 / ratio); (inc * recip) >> 32 is the quotient or one below it
	localparam logic [63:0] RECIP_NUM = 64'd1 << 48;

	typedef enum logic [1:0] {
		TBL_NONE,
		TBL_MUL,
		TBL_DIV
	} tbl_op_t;

	typedef struct packed {
		logic [INC_W-1:0]   inc;
		tbl_op_t            op;
		logic [RATIO_W-1:0] ratio;
		logic [INC_W-1:0]   recip;
		logic [ADJ_W-1:0]   adj;
	} sps_item_t;

	function automatic logic [RATIO_W-1:0] ratio_q16(input logic [3:0] idx);
		logic [RATIO_W-1:0] r;
		unique case (idx)
			4'd1:    r = 17'd69433;
			4'd2:    r = 17'd73562;
			4'd3:    r = 17'd77936;
			4'd4:    r = 17'd82570;
			4'd5:    r = 17'd87480;
			4'd6:    r = 17'd92681;
			4'd7:    r = 17'd98193;
			4'd8:    r = 17'd104032;
			4'd9:    r = 17'd110218;
			4'd10:   r = 17'd116772;
			4'd11:   r = 17'd123715;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

	function automatic logic [INC_W-1:0] recip_q48(input logic [3:0] idx);
		logic [INC_W-1:0] r;
		unique case (idx)
			4'd1:    r = 32'(RECIP_NUM / 64'd69433);
			4'd2:    r = 32'(RECIP_NUM / 64'd73562);
			4'd3:    r = 32'(RECIP_NUM / 64'd77936);
			4'd4:    r = 32'(RECIP_NUM / 64'd82570);
			4'd5:    r = 32'(RECIP_NUM / 64'd87480);
			4'd6:    r = 32'(RECIP_NUM / 64'd92681);
			4'd7:    r = 32'(RECIP_NUM / 64'd98193);
			4'd8:    r = 32'(RECIP_NUM / 64'd104032);
			4'd9:    r = 32'(RECIP_NUM / 64'd110218);
			4'd10:   r = 32'(RECIP_NUM / 64'd116772);
			4'd11:   r = 32'(RECIP_NUM / 64'd123715);
			default: r = '0;   // unison never divides
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/semitone_phase_increment_scaler.sv
// ----------------------------------------------------------------------------
// semitone_phase_increment_scaler
// Retunes an oscillator phase increment by an interval in semitones and a
// detune in cents, using a Q16 equal-tempered ratio table.
//
//  channel | signals                                             | dir
//  --------+-----------------------------------------------------+-----
//  in      | in_valid, in_ready, root_increment,                 | in
//          | interval_semitones, detune_cents                    |
//  out     | out_valid, out_ready, scaled_increment              | out
//
// One transaction per clock while the output is not stalled; six register
// stages, two in sps_front and four here (s3, s4, s5 and the output).
// Downward semitones divide by a reciprocal multiply, a remainder and a
// one-step correction; every item passes all stages, so order holds.
// Reset clears the stage valid bits only.
// Each stage takes new data when it is empty or its successor moves, so
// bubbles close up under output backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module semitone_phase_increment_scaler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        root_increment,
	input  logic signed [7:0]  interval_semitones,
	input  logic signed [11:0] detune_cents,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        scaled_increment
);
	import sps_pkg::*;

	`include "assert_macros.svh"

	logic      front_valid;
	sps_item_t front_item;

	// stage 3: table multiply or quotient estimate
	logic               v_s3;
	logic [INC_W-1:0]   word_s3;
	logic [1:0]         lo_s3;
	logic [RATIO_W-1:0] ratio_s3;
	tbl_op_t            op_s3;
	logic [ADJ_W-1:0]   adj_s3;

	// stage 4: remainder left by the estimate
	logic               v_s4;
	logic [INC_W-1:0]   word_s4;
	logic [REM_W-1:0]   rem_s4;
	logic [RATIO_W-1:0] ratio_s4;
	tbl_op_t            op_s4;
	logic [ADJ_W-1:0]   adj_s4;

	// stage 5: corrected quotient
	logic               v_s5;
	logic [INC_W-1:0]   word_s5;
	logic [ADJ_W-1:0]   adj_s5;

	logic             out_valid_q;
	logic [INC_W-1:0] scaled_q;

	logic rdy_s3, rdy_s4, rdy_s5, rdy_out;

	logic [INC_W-1:0] mul_op;
	logic [63:0]      tbl_prod;
	logic [REM_W-1:0] rem_c;
	logic             fix_c;
	logic [49:0]      cents_prod;

	sps_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.root_increment     (root_increment),
		.interval_semitones (interval_semitones),
		.detune_cents       (detune_cents),
		.out_valid          (front_valid),
		.out_ready          (rdy_s3),
		.out_item           (front_item)
	);

	assign rdy_out = !out_valid_q || out_ready;
	assign rdy_s5  = !v_s5 || rdy_out;
	assign rdy_s4  = !v_s4 || rdy_s5;
	assign rdy_s3  = !v_s3 || rdy_s4;

	// one multiplier: ratio for up and unison (65536 passes through),
	// reciprocal for down
	assign mul_op   = (front_item.op == TBL_DIV) ? front_item.recip
	                                             : INC_W'(front_item.ratio);
	assign tbl_prod = 64'(front_item.inc) * 64'(mul_op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= front_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && front_valid) begin
			lo_s3    <= front_item.inc[1:0];
			ratio_s3 <= front_item.ratio;
			op_s3    <= front_item.op;
			adj_s3   <= front_item.adj;
			case (front_item.op)
				TBL_DIV: word_s3 <= tbl_prod[63:32];
				default: word_s3 <= tbl_prod[47:16];
			endcase
		end
	end

	// remainder of (inc << 16) - q * ratio lies below 2 * ratio, so the low
	// bits are enough
	assign rem_c = {lo_s3, 16'd0} - REM_W'(word_s3) * REM_W'(ratio_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			word_s4  <= word_s3;
			rem_s4   <= (op_s3 == TBL_DIV) ? rem_c : '0;
			ratio_s4 <= ratio_s3;
			op_s4    <= op_s3;
			adj_s4   <= adj_s3;
		end
	end

	assign fix_c = (op_s4 == TBL_DIV) && (rem_s4 >= {1'b0, ratio_s4});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			word_s5 <= word_s4 + INC_W'(fix_c);
			adj_s5  <= adj_s4;
		end
	end

	// cents: factor of unity (zero detune) passes the value through unchanged
	assign cents_prod = 50'(word_s5) * 50'(adj_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s5) begin
			scaled_q <= cents_prod[47:16];
		end
	end

	assign out_valid        = out_valid_q;
	assign scaled_increment = scaled_q;

	`ASSERT_IMPLY(a_div_rem_bound, clk, arst_n,
		v_s4 && (op_s4 == TBL_DIV), rem_s4 < {ratio_s4, 1'b0})
	`ASSERT_IMPLY(a_nodiv_rem_zero, clk, arst_n,
		v_s4 && (op_s4 != TBL_DIV), rem_s4 == '0)
	`ASSERT_NEXT(a_tail_hold, clk, arst_n, v_s5 && !rdy_out,
		v_s5 && $stable(word_s5))
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && !out_ready,
		out_valid_q && $stable(scaled_q))

endmodule

`default_nettype wire

FILE: rtl/sps_front.sv
// ----------------------------------------------------------------------------
// sps_front
// Two pipeline stages: interval decode and cents factor, then the octave
// shift with early stop and selection of the semitone table operation.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [31:0]             root_increment,
	input  logic signed [7:0]       interval_semitones,
	input  logic signed [11:0]      detune_cents,
	output logic                    out_valid,
	input  logic                    out_ready,
	output sps_pkg::sps_item_t      out_item
);
	import sps_pkg::*;

	`include "assert_macros.svh"

	// stage 1
	logic             v_s1;
	logic [INC_W-1:0] inc_s1;
	logic             neg_s1;
	logic [3:0]       q_s1;
	logic [3:0]       r_s1;
	logic [ADJ_W-1:0] adj_s1;

	// stage 2
	logic      v_s2;
	sps_item_t item_s2;

	logic rdy_s1, rdy_s2;

	logic [7:0]              mag;
	logic [15:0]             q_prod;
	logic [3:0]              q_c;
	logic [7:0]              r_full;
	logic signed [18:0]      adj_sum;
	logic [ADJ_W-1:0]        adj_c;

	logic [3:0]       t_c;
	logic             early_c;
	logic [INC_W-1:0] shifted_c;
	tbl_op_t          op_c;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// interval magnitude split into octaves and semitones
	always_comb begin
		mag     = interval_semitones[7] ? 8'(~interval_semitones + 8'sd1)
		                                : 8'(interval_semitones);
		q_prod  = 16'(mag) * SEMI_RECIP;
		q_c     = q_prod[SEMI_RECIP_SHIFT+3:SEMI_RECIP_SHIFT];
		r_full  = mag - 8'({4'd0, q_c}) * SEMIS_PER_OCTAVE;
		adj_sum = UNITY_Q16 + 19'(detune_cents) * CENTS_STEP_Q16;
		if (adj_sum < 19'sd1) begin
			adj_c = ADJ_W'(1);
		end else begin
			adj_c = adj_sum[ADJ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			inc_s1 <= root_increment;
			neg_s1 <= interval_semitones[7];
			q_s1   <= q_c;
			r_s1   <= r_full[3:0];
			adj_s1 <= adj_c;
		end
	end

	// octave up stops at the first shift that sets bit 31
	always_comb begin
		t_c = q_s1;
		if (!neg_s1) begin
			for (int j = OCT_MAX; j >= 1; j--) begin
				if ((4'(j) <= q_s1) && inc_s1[INC_W-1-j]) begin
					t_c = 4'(j);
				end
			end
		end
		early_c   = (t_c != q_s1);
		shifted_c = neg_s1 ? (inc_s1 >> q_s1) : (inc_s1 << t_c);
		if (early_c || (r_s1 == 4'd0)) begin
			op_c = TBL_NONE;
		end else if (neg_s1) begin
			op_c = TBL_DIV;
		end else begin
			op_c = TBL_MUL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			item_s2.inc   <= shifted_c;
			item_s2.op    <= op_c;
			item_s2.ratio <= (op_c == TBL_NONE) ? ratio_q16(4'd0) : ratio_q16(r_s1);
			item_s2.recip <= (op_c == TBL_DIV) ? recip_q48(r_s1) : '0;
			item_s2.adj   <= adj_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

	`ASSERT_IMPLY(a_adj_nonzero, clk, arst_n, v_s1, adj_s1 != '0)
	`ASSERT_IMPLY(a_rem_range, clk, arst_n, v_s1, r_s1 < 4'(SEMIS_PER_OCTAVE))
	`ASSERT_IMPLY(a_unity_none, clk, arst_n,
		v_s2 && (item_s2.op == TBL_NONE), item_s2.ratio == ratio_q16(4'd0))

endmodule

`default_nettype wire
